// ===== design/ode_pkg.sv =====
// ============================================================================
// ode_pkg - shared types and constants for the OLED draw command encoder
// Request kinds, the classified command record, the configuration set and
// the queue status bundle.
// ============================================================================
package ode_pkg;

    // request kinds as they arrive on the operation port
    typedef enum logic [1:0] {
        OP_PIXEL = 2'd0,
        OP_LINE  = 2'd1,
        OP_RECT  = 2'd2
    } op_kind_t;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PANEL_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PANEL_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OP_SET_COL   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OP_SET_ROW   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OP_LINE      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_OP_RECT      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_OP_FILL      = 3'd6;

    // register reset values
    localparam logic [7:0] RST_PANEL_WIDTH  = 8'd96;
    localparam logic [7:0] RST_PANEL_HEIGHT = 8'd64;
    localparam logic [7:0] RST_OP_SET_COL   = 8'd21;
    localparam logic [7:0] RST_OP_SET_ROW   = 8'd117;
    localparam logic [7:0] RST_OP_LINE      = 8'd33;
    localparam logic [7:0] RST_OP_RECT      = 8'd34;
    localparam logic [7:0] RST_OP_FILL      = 8'd38;

    // byte that follows the fill-mode opcode
    localparam logic [7:0] FILL_ENABLE_BYTE = 8'h01;

    // byte sequencer
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] LAST_STEP_SHORT = 4'd7;   // pixel, line: 8 bytes
    localparam logic [STEP_W-1:0] LAST_STEP_RECT  = 4'd12;  // rectangle: 13 bytes

    // command queue between front and back
    localparam int CMD_FIFO_DEPTH = 2;

    typedef struct packed {
        logic [7:0] panel_width;
        logic [7:0] panel_height;
        logic [7:0] op_set_col;
        logic [7:0] op_set_row;
        logic [7:0] op_line;
        logic [7:0] op_rect;
        logic [7:0] op_fill;
    } cfg_t;

    // classified request; line coordinates already ordered
    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  x0;
        logic [7:0]  y0;
        logic [7:0]  x1;
        logic [7:0]  y1;
        logic [15:0] color;
        logic [15:0] fill_color;
    } draw_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

endpackage

// ===== design/ode_front.sv =====
// ============================================================================
// ode_front - request intake and classification
// Checks coordinates against the panel, orders line endpoints, and holds the
// classified command in one register until the command queue takes it.
// ============================================================================
module ode_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ode_pkg::cfg_t           cfg,
    input  logic                    push,
    output logic                    full,
    input  logic [1:0]              operation,
    input  logic [7:0]              x_start,
    input  logic [7:0]              y_start,
    input  logic [7:0]              x_end,
    input  logic [7:0]              y_end,
    input  logic [15:0]             color,
    input  logic [15:0]             fill_color,
    input  ode_pkg::fifo_status_t   q_status,
    output logic                    q_push,
    output ode_pkg::draw_cmd_t      q_data
);
    import ode_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    draw_cmd_t  cmd_reg;
    draw_cmd_t  cmd_next;
    draw_cmd_t  cls_cmd;
    logic       cls_keep;
    logic       start_in;
    logic       end_in;
    logic       accept;

    assign q_push = valid_reg && !q_status.full;
    assign q_data = cmd_reg;
    assign full   = valid_reg && q_status.full;
    assign accept = push && !full;

    assign start_in = (x_start < cfg.panel_width) && (y_start < cfg.panel_height);
    assign end_in   = (x_end < cfg.panel_width) && (y_end < cfg.panel_height);

    always_comb
    begin
        cls_cmd.color      = color;
        cls_cmd.fill_color = fill_color;
        cls_cmd.x0         = x_start;
        cls_cmd.y0         = y_start;
        cls_cmd.x1         = x_end;
        cls_cmd.y1         = y_end;
        cls_cmd.kind       = OP_PIXEL;
        cls_keep           = 1'b0;
        unique case (operation)
            OP_PIXEL:
            begin
                cls_keep = start_in;
            end
            OP_LINE:
            begin
                cls_cmd.kind = OP_LINE;
                cls_keep     = start_in && end_in;
                if (x_end < x_start)
                begin
                    cls_cmd.x0 = x_end;
                    cls_cmd.x1 = x_start;
                end
                if (y_end < y_start)
                begin
                    cls_cmd.y0 = y_end;
                    cls_cmd.y1 = y_start;
                end
            end
            OP_RECT:
            begin
                cls_cmd.kind = OP_RECT;
                cls_keep     = start_in && end_in;
            end
            default:
            begin
                cls_keep = 1'b0;    // undefined request: dropped
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (accept)
        begin
            valid_next = cls_keep;
            cmd_next   = cls_cmd;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

// ===== design/ode_cmd_fifo.sv =====
// ============================================================================
// ode_cmd_fifo - short command queue
// Decouples classification from byte sequencing; head is read in place.
// ============================================================================
module ode_cmd_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ode_pkg::draw_cmd_t      wr_data,
    input  logic                    pop,
    output ode_pkg::draw_cmd_t      rd_data,
    output ode_pkg::fifo_status_t   status
);
    import ode_pkg::*;

    localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(CMD_FIFO_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(CMD_FIFO_DEPTH - 1);

    draw_cmd_t          mem [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == DEPTH_CNT);
    assign rd_data      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("cmd fifo count above depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && status.full && !pop))
        else $error("cmd fifo push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && status.empty))
        else $error("cmd fifo pop while empty");

endmodule

// ===== design/ode_back.sv =====
// ============================================================================
// ode_back - byte sequencer
// Walks the head command one byte per cycle into an output register while pop keeps it free.
// ============================================================================
module ode_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ode_pkg::cfg_t           cfg,
    input  ode_pkg::draw_cmd_t      cmd,
    input  ode_pkg::fifo_status_t   q_status,
    output logic                    q_pop,
    output logic                    empty,
    input  logic                    pop,
    output logic [7:0]              out_byte,
    output logic                    is_data,
    output logic                    last
);
    import ode_pkg::*;

    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [7:0]         out_byte_reg;
    logic [7:0]         out_byte_next;
    logic               is_data_reg;
    logic               is_data_next;
    logic               last_reg;
    logic               last_next;
    logic               advance;
    logic               fire;
    logic               step_last;
    logic [7:0]         seq_byte;
    logic               seq_data;
    logic [15:0]        rgb;

    assign empty    = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign is_data  = is_data_reg;
    assign last     = last_reg;

    assign advance   = !out_valid_reg || pop;
    assign fire      = advance && !q_status.empty;
    assign step_last = (cmd.kind == OP_RECT) ? (step_reg == LAST_STEP_RECT)
                                             : (step_reg == LAST_STEP_SHORT);
    assign q_pop     = fire && step_last;

    // rectangle: pen color on steps 7..9, fill color on 10..12
    assign rgb = (step_reg < 4'd10) ? cmd.color : cmd.fill_color;

    always_comb
    begin
        seq_byte = '0;
        seq_data = 1'b0;
        unique case (cmd.kind)
            OP_PIXEL:
            begin
                case (step_reg)
                    4'd0:    seq_byte = cfg.op_set_col;
                    4'd1:    seq_byte = cmd.x0;
                    4'd2:    seq_byte = cfg.panel_width - 8'd1;
                    4'd3:    seq_byte = cfg.op_set_row;
                    4'd4:    seq_byte = cmd.y0;
                    4'd5:    seq_byte = cfg.panel_height - 8'd1;
                    4'd6:
                    begin
                        seq_byte = cmd.color[15:8];
                        seq_data = 1'b1;
                    end
                    default:
                    begin
                        seq_byte = cmd.color[7:0];
                        seq_data = 1'b1;
                    end
                endcase
            end
            OP_LINE:
            begin
                case (step_reg)
                    4'd0:    seq_byte = cfg.op_line;
                    4'd1:    seq_byte = cmd.x0;
                    4'd2:    seq_byte = cmd.y0;
                    4'd3:    seq_byte = cmd.x1;
                    4'd4:    seq_byte = cmd.y1;
                    4'd5:    seq_byte = {3'b000, cmd.color[15:11]};
                    4'd6:    seq_byte = {2'b00, cmd.color[10:5]};
                    default: seq_byte = {3'b000, cmd.color[4:0]};
                endcase
            end
            default:
            begin
                case (step_reg)
                    4'd0:               seq_byte = cfg.op_fill;
                    4'd1:               seq_byte = FILL_ENABLE_BYTE;
                    4'd2:               seq_byte = cfg.op_rect;
                    4'd3:               seq_byte = cmd.x0;
                    4'd4:               seq_byte = cmd.y0;
                    4'd5:               seq_byte = cmd.x1;
                    4'd6:               seq_byte = cmd.y1;
                    4'd7, 4'd10:        seq_byte = {2'b00, rgb[15:11], 1'b0};
                    4'd8, 4'd11:        seq_byte = {2'b00, rgb[10:5]};
                    default:            seq_byte = {2'b00, rgb[4:0], 1'b0};
                endcase
            end
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        is_data_next   = is_data_reg;
        last_next      = last_reg;
        if (fire)
        begin
            step_next      = step_last ? '0 : step_reg + 1'b1;
            out_valid_next = 1'b1;
            out_byte_next  = seq_byte;
            is_data_next   = seq_data;
            last_next      = step_last;
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        is_data_reg  <= is_data_next;
        last_reg     <= last_next;
    end

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= LAST_STEP_RECT)
        else $error("sequencer step out of range");

    a_mid_cmd_held: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != '0) |-> !q_status.empty)
        else $error("command left the queue mid-sequence");

    a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (step_reg == '0) && last_reg && out_valid_reg)
        else $error("final beat did not rewind sequencer");

endmodule

// ===== design/oled_draw_command_encoder.sv =====
// ============================================================================
// oled_draw_command_encoder - drawing request to OLED controller byte stream
// Top level: configuration registers, front classifier, command queue and
// byte sequencer.
// ============================================================================
// A request is pushed as one beat and comes out as a run of byte beats, each
// flagged command (is_data low) or data (is_data high), with last set on the
// final beat of the run: 8 beats for a pixel or a line, 13 for a filled
// rectangle. A request with an operation code of 3, or with any coordinate it
// uses at or beyond the panel width/height, produces no beats at all. The
// byte sequencer emits one beat per clock while pop keeps its output free,
// and that sequencer sets the sustained rate. The front accepts a new
// request every cycle while its holding register or the two-entry command
// queue behind it has room, so up to two requests can wait behind the one
// being sent, and a dropped request is accepted like any other but never
// enters the queue. The first beat of a request passes through the front
// register, then the queue, then the output register before it reaches the
// byte ports. Configuration writes take effect at the next edge and must
// only be made while nothing is in flight.
// ============================================================================
module oled_draw_command_encoder (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_write,
    input  logic [ode_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [7:0]                          cfg_data,
    // request side
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          operation,
    input  logic [7:0]                          x_start,
    input  logic [7:0]                          y_start,
    input  logic [7:0]                          x_end,
    input  logic [7:0]                          y_end,
    input  logic [15:0]                         color,
    input  logic [15:0]                         fill_color,
    // byte side
    output logic                                empty,
    input  logic                                pop,
    output logic [7:0]                          out_byte,
    output logic                                is_data,
    output logic                                last
);
    import ode_pkg::*;

    cfg_t           cfg_reg;
    cfg_t           cfg_next;
    fifo_status_t   q_status;
    logic           q_push;
    logic           q_pop;
    draw_cmd_t      q_wr_data;
    draw_cmd_t      q_rd_data;

    // register file; an index with no register behind it is ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PANEL_WIDTH:  cfg_next.panel_width  = cfg_data;
                CFG_PANEL_HEIGHT: cfg_next.panel_height = cfg_data;
                CFG_OP_SET_COL:   cfg_next.op_set_col   = cfg_data;
                CFG_OP_SET_ROW:   cfg_next.op_set_row   = cfg_data;
                CFG_OP_LINE:      cfg_next.op_line      = cfg_data;
                CFG_OP_RECT:      cfg_next.op_rect      = cfg_data;
                CFG_OP_FILL:      cfg_next.op_fill      = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.panel_width  <= RST_PANEL_WIDTH;
            cfg_reg.panel_height <= RST_PANEL_HEIGHT;
            cfg_reg.op_set_col   <= RST_OP_SET_COL;
            cfg_reg.op_set_row   <= RST_OP_SET_ROW;
            cfg_reg.op_line      <= RST_OP_LINE;
            cfg_reg.op_rect      <= RST_OP_RECT;
            cfg_reg.op_fill      <= RST_OP_FILL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: bounds check, line ordering, one holding register
    ode_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .full       (full),
        .operation  (operation),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .color      (color),
        .fill_color (fill_color),
        .q_status   (q_status),
        .q_push     (q_push),
        .q_data     (q_wr_data)
    );

    // command queue: lets intake and sequencing stall independently
    ode_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    // back: one byte beat per cycle into the output register while pop keeps it free
    ode_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd      (q_rd_data),
        .q_status (q_status),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .is_data  (is_data),
        .last     (last)
    );

endmodule
